[hw/rtl/prpz_pkg.sv]
// ----------------------------------------------------------------------------
// prpz_pkg
// Shared types and constants for the point rotate, project and z-buffer block.
// ----------------------------------------------------------------------------
`default_nettype none

package prpz_pkg;

  // input beat: plot a point or read and clear a cell
  typedef struct packed {
    logic              cmd;
    logic signed [7:0] point_i;
    logic signed [7:0] point_j;
    logic signed [7:0] point_k;
    logic [7:0]        glyph;
    logic [12:0]       cell_index;
  } in_item_t;

  // output beat: glyph read from a cell
  typedef struct packed {
    logic [7:0]  cell_glyph;
    logic [12:0] cell_index_echo;
  } out_item_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_COS_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_B      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_B      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_C      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_C      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_DIST   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_SCALE = 3'd7;

  // background values
  localparam logic [7:0]  BLANK_GLYPH = 8'd32;
  localparam logic [15:0] FAR_DEPTH   = 16'hFFFF;

  // sequencing of the shared multiplier and the dividers
  localparam int STEP_W     = 5;
  localparam logic [STEP_W-1:0] CALC_LAST = 5'd23;
  localparam logic [STEP_W-1:0] IDX_FIRST = 5'd24;
  localparam logic [STEP_W-1:0] IDX_LAST  = 5'd27;
  localparam int NUM_W      = 52;
  localparam int DIV_STEPS  = NUM_W - 1;
  localparam int DIV_CNT_W  = 6;

  // controller to datapath commands
  typedef struct packed {
    logic              take_item;
    logic              calc;
    logic [STEP_W-1:0] step;
    logic              div_init;
    logic              div_step;
    logic              div_fix;
    logic              clr;
    logic              rd_cell;
    logic              rd_plot;
    logic              wr_blank;
    logic              wr_plot;
    logic              out_load;
  } dp_cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic z_pos;
    logic idx_ok;
    logic cell_ok;
    logic nearer;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/point_rotate_project_zbuffer_top.sv]
// ----------------------------------------------------------------------------
// point_rotate_project_zbuffer_top
// Rotates a point, projects it in perspective onto a character grid and
// keeps the nearest glyph per cell; read beats return and clear a cell.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all cells of the
// SCREEN_WIDTH*SCREEN_HEIGHT grid (7040 by default), one cell a cycle, and
// stalls input until done; configuration writes are taken throughout. A plot
// beat takes 24 steps on the one shared 24x17 multiplier for rotation and
// projection numerators, 51 steps of the two restoring dividers for the two
// projected coordinates, 4 more multiplier steps for the row-major index, and
// a read-compare-write of the depth memory. A read beat reads the cell, then
// loads the output register once it is free. One beat is in work at a time.
`default_nettype none

module point_rotate_project_zbuffer_top import prpz_pkg::*; #(
  parameter int SCREEN_WIDTH    = 160,
  parameter int SCREEN_HEIGHT   = 44,
  parameter int CUBE_HALF_WIDTH = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  in_item_t                   in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  prpz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_read_i  (in_item_i.cmd),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // arithmetic, memories and output register
  prpz_dp #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .CUBE_HALF_WIDTH (CUBE_HALF_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

[hw/rtl/prpz_ctrl.sv]
// ----------------------------------------------------------------------------
// prpz_ctrl
// Sequencer: clearing pass, multiply steps, divide, index and z-buffer access.
// ----------------------------------------------------------------------------
`default_nettype none

module prpz_ctrl import prpz_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_read_i,
  output logic      in_stall_o,
  output dp_cmd_t   cmd_o,
  input  dp_sts_t   sts_i
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CALC, ST_DIVI, ST_DIV, ST_FIX, ST_INDEX,
    ST_PLOT_RD, ST_PLOT_WR, ST_CELL_RD, ST_CELL_OUT
  } state_e;

  state_e                state_q;
  logic [STEP_W-1:0]     step_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;

  // command decode
  always_comb begin
    cmd_o      = '0;
    cmd_o.step = step_q;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_CLEAR:    cmd_o.clr = 1'b1;
      ST_IDLE:     cmd_o.take_item = in_valid_i;
      ST_CALC:     cmd_o.calc = 1'b1;
      ST_DIVI:     cmd_o.div_init = sts_i.z_pos;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_FIX:      cmd_o.div_fix = 1'b1;
      ST_INDEX:    cmd_o.calc = 1'b1;
      ST_PLOT_RD:  cmd_o.rd_plot = sts_i.idx_ok;
      ST_PLOT_WR:  cmd_o.wr_plot = sts_i.nearer;
      ST_CELL_RD:  cmd_o.rd_cell = sts_i.cell_ok;
      ST_CELL_OUT: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.wr_blank = sts_i.out_free & sts_i.cell_ok;
      end
      default:     cmd_o = '0;
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      step_q    <= '0;
      div_cnt_q <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          step_q <= '0;
          if (in_valid_i) state_q <= in_read_i ? ST_CELL_RD : ST_CALC;
        end
        ST_CALC: begin
          step_q <= step_q + 1'b1;
          if (step_q == CALC_LAST) state_q <= ST_DIVI;
        end
        ST_DIVI: begin
          div_cnt_q <= '0;
          state_q   <= sts_i.z_pos ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_q <= ST_FIX;
        end
        ST_FIX: begin
          step_q  <= IDX_FIRST;
          state_q <= ST_INDEX;
        end
        ST_INDEX: begin
          step_q <= step_q + 1'b1;
          if (step_q == IDX_LAST) state_q <= ST_PLOT_RD;
        end
        ST_PLOT_RD:  state_q <= sts_i.idx_ok ? ST_PLOT_WR : ST_IDLE;
        ST_PLOT_WR:  state_q <= ST_IDLE;
        ST_CELL_RD:  state_q <= ST_CELL_OUT;
        ST_CELL_OUT: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default:     state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/prpz_dp.sv]
// ----------------------------------------------------------------------------
// prpz_dp
// Datapath: config registers, shared multiplier with accumulator, two
// restoring dividers, glyph and depth memories, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module prpz_dp import prpz_pkg::*; #(
  parameter int SCREEN_WIDTH    = 160,
  parameter int SCREEN_HEIGHT   = 44,
  parameter int CUBE_HALF_WIDTH = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_sts_t                    sts_o,
  input  in_item_t                   in_item_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o
);

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int XOFF  = SCREEN_WIDTH / 2 - 2 * CUBE_HALF_WIDTH;
  localparam int YOFF  = SCREEN_HEIGHT / 2;

  typedef enum logic [4:0] {
    A_NONE, A_I, A_J, A_K, A_ONE, A_P, A_Q, A_R_LO, A_R_HI, A_X_LO, A_X_HI,
    A_Y_LO, A_Y_HI, A_Z_LO, A_Z_HI, A_YQ_LO, A_YQ_MID, A_YQ_HI
  } a_sel_e;

  typedef enum logic [3:0] {
    B_NONE, B_SA, B_CA, B_SB, B_CB, B_SC, B_CC, B_CD, B_K1, B_K2, B_XOFF,
    B_YOFF, B_W
  } b_sel_e;

  typedef enum logic [2:0] {
    AC_NONE, AC_LOAD, AC_LOADNEG, AC_ADD, AC_SUB, AC_XADD
  } acc_e;

  typedef enum logic [2:0] {SH0, SH14, SH20, SH28, SH40} sh_e;

  typedef enum logic [3:0] {
    D_NONE, D_P, D_Q, D_R, D_Z, D_X, D_Y, D_NX, D_NY, D_IDX
  } dst_e;

  typedef struct packed {
    a_sel_e a_sel;
    b_sel_e b_sel;
    acc_e   acc;
    sh_e    sh;
    dst_e   dst;
  } op_t;

  // micro-program: multiply in step n, accumulate that product in step n+1
  function automatic op_t op_of(input logic [STEP_W-1:0] step);
    op_t op;
    case (step)
      5'd0:  op = '{A_J,     B_SA,   AC_NONE,    SH0,  D_NONE};
      5'd1:  op = '{A_K,     B_CA,   AC_LOAD,    SH0,  D_NONE};
      5'd2:  op = '{A_J,     B_CA,   AC_SUB,     SH0,  D_P};
      5'd3:  op = '{A_K,     B_SA,   AC_LOAD,    SH0,  D_NONE};
      5'd4:  op = '{A_P,     B_SB,   AC_ADD,     SH0,  D_Q};
      5'd5:  op = '{A_I,     B_CB,   AC_LOAD,    SH0,  D_NONE};
      5'd6:  op = '{A_I,     B_SB,   AC_ADD,     SH14, D_R};
      5'd7:  op = '{A_P,     B_CB,   AC_LOAD,    SH14, D_NONE};
      5'd8:  op = '{A_ONE,   B_CD,   AC_SUB,     SH0,  D_NONE};
      5'd9:  op = '{A_R_LO,  B_CC,   AC_ADD,     SH28, D_Z};
      5'd10: op = '{A_R_HI,  B_CC,   AC_LOAD,    SH0,  D_NONE};
      5'd11: op = '{A_Q,     B_SC,   AC_ADD,     SH20, D_NONE};
      5'd12: op = '{A_R_LO,  B_SC,   AC_ADD,     SH14, D_X};
      5'd13: op = '{A_R_HI,  B_SC,   AC_LOADNEG, SH0,  D_NONE};
      5'd14: op = '{A_Q,     B_CC,   AC_SUB,     SH20, D_NONE};
      5'd15: op = '{A_Z_LO,  B_XOFF, AC_ADD,     SH14, D_Y};
      5'd16: op = '{A_Z_HI,  B_XOFF, AC_LOAD,    SH0,  D_NONE};
      5'd17: op = '{A_X_LO,  B_K2,   AC_ADD,     SH20, D_NONE};
      5'd18: op = '{A_X_HI,  B_K2,   AC_ADD,     SH0,  D_NONE};
      5'd19: op = '{A_Z_LO,  B_YOFF, AC_ADD,     SH20, D_NX};
      5'd20: op = '{A_Z_HI,  B_YOFF, AC_LOAD,    SH0,  D_NONE};
      5'd21: op = '{A_Y_LO,  B_K1,   AC_ADD,     SH20, D_NONE};
      5'd22: op = '{A_Y_HI,  B_K1,   AC_ADD,     SH0,  D_NONE};
      5'd23: op = '{A_NONE,  B_NONE, AC_ADD,     SH20, D_NY};
      5'd24: op = '{A_YQ_LO, B_W,    AC_NONE,    SH0,  D_NONE};
      5'd25: op = '{A_YQ_MID, B_W,   AC_XADD,    SH0,  D_NONE};
      5'd26: op = '{A_YQ_HI, B_W,    AC_ADD,     SH20, D_NONE};
      5'd27: op = '{A_NONE,  B_NONE, AC_ADD,     SH40, D_IDX};
      default: op = '{A_NONE, B_NONE, AC_NONE,   SH0,  D_NONE};
    endcase
    return op;
  endfunction

  // coordinate to whole units, truncated toward zero
  function automatic logic signed [5:0] whole(input logic signed [7:0] p);
    logic signed [8:0] t;
    t = {p[7], p} + (p[7] ? 9'sd3 : 9'sd0);
    return t[7:2];
  endfunction

  // configuration registers
  logic signed [15:0] cos_a_q, sin_a_q, cos_b_q, sin_b_q, cos_c_q, sin_c_q;
  logic [7:0]         cam_dist_q, proj_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_a_q      <= 16'sd16384;
      sin_a_q      <= '0;
      cos_b_q      <= 16'sd16384;
      sin_b_q      <= '0;
      cos_c_q      <= 16'sd16384;
      sin_c_q      <= '0;
      cam_dist_q   <= 8'd100;
      proj_scale_q <= 8'd40;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COS_A:      cos_a_q      <= cfg_data_i;
        REG_SIN_A:      sin_a_q      <= cfg_data_i;
        REG_COS_B:      cos_b_q      <= cfg_data_i;
        REG_SIN_B:      sin_b_q      <= cfg_data_i;
        REG_COS_C:      cos_c_q      <= cfg_data_i;
        REG_SIN_C:      sin_c_q      <= cfg_data_i;
        REG_CAM_DIST:   cam_dist_q   <= cfg_data_i[7:0];
        REG_PROJ_SCALE: proj_scale_q <= cfg_data_i[7:0];
        default:        cam_dist_q   <= cam_dist_q;
      endcase
    end
  end

  // item registers
  logic signed [5:0] i_q, j_q, k_q;
  logic [7:0]        glyph_q;
  logic [12:0]       cell_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      i_q     <= whole(in_item_i.point_i);
      j_q     <= whole(in_item_i.point_j);
      k_q     <= whole(in_item_i.point_k);
      glyph_q <= in_item_i.glyph;
      cell_q  <= in_item_i.cell_index;
    end
  end

  // intermediate results
  logic signed [22:0]      p_q, q_q;
  logic signed [37:0]      r_q;
  logic signed [40:0]      z_q, x_q, y_q;
  logic signed [NUM_W-1:0] nx_q, ny_q, xq_q, yq_q;
  logic signed [63:0]      idx_q;

  op_t                op;
  logic signed [23:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [40:0] prod_q;
  logic signed [63:0] term, acc_q, acc_d;

  assign op = op_of(cmd_i.step);

  // multiplier operand select
  always_comb begin
    case (op.a_sel)
      A_I:      mul_a = 24'(i_q);
      A_J:      mul_a = 24'(j_q);
      A_K:      mul_a = 24'(k_q);
      A_ONE:    mul_a = 24'sd1;
      A_P:      mul_a = 24'(p_q);
      A_Q:      mul_a = 24'(q_q);
      A_R_LO:   mul_a = {4'b0, r_q[19:0]};
      A_R_HI:   mul_a = 24'($signed(r_q[37:20]));
      A_X_LO:   mul_a = {4'b0, x_q[19:0]};
      A_X_HI:   mul_a = 24'($signed(x_q[40:20]));
      A_Y_LO:   mul_a = {4'b0, y_q[19:0]};
      A_Y_HI:   mul_a = 24'($signed(y_q[40:20]));
      A_Z_LO:   mul_a = {4'b0, z_q[19:0]};
      A_Z_HI:   mul_a = 24'($signed(z_q[40:20]));
      A_YQ_LO:  mul_a = {4'b0, yq_q[19:0]};
      A_YQ_MID: mul_a = {4'b0, yq_q[39:20]};
      A_YQ_HI:  mul_a = 24'($signed(yq_q[NUM_W-1:40]));
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    case (op.b_sel)
      B_SA:    mul_b = 17'(sin_a_q);
      B_CA:    mul_b = 17'(cos_a_q);
      B_SB:    mul_b = 17'(sin_b_q);
      B_CB:    mul_b = 17'(cos_b_q);
      B_SC:    mul_b = 17'(sin_c_q);
      B_CC:    mul_b = 17'(cos_c_q);
      B_CD:    mul_b = {9'b0, cam_dist_q};
      B_K1:    mul_b = {9'b0, proj_scale_q};
      B_K2:    mul_b = {8'b0, proj_scale_q, 1'b0};
      B_XOFF:  mul_b = 17'(XOFF);
      B_YOFF:  mul_b = 17'(YOFF);
      B_W:     mul_b = 17'(SCREEN_WIDTH);
      default: mul_b = '0;
    endcase
  end

  // shifted product and accumulator
  always_comb begin
    case (op.sh)
      SH14:    term = 64'(prod_q) <<< 14;
      SH20:    term = 64'(prod_q) <<< 20;
      SH28:    term = 64'(prod_q) <<< 28;
      SH40:    term = 64'(prod_q) <<< 40;
      default: term = 64'(prod_q);
    endcase
    case (op.acc)
      AC_LOAD:    acc_d = term;
      AC_LOADNEG: acc_d = -term;
      AC_ADD:     acc_d = acc_q + term;
      AC_SUB:     acc_d = acc_q - term;
      AC_XADD:    acc_d = 64'(xq_q) + term;
      default:    acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      prod_q <= mul_a * mul_b;
      acc_q  <= acc_d;
      case (op.dst)
        D_P:     p_q   <= acc_d[22:0];
        D_Q:     q_q   <= acc_d[22:0];
        D_R:     r_q   <= acc_d[37:0];
        D_Z:     z_q   <= acc_d[40:0];
        D_X:     x_q   <= acc_d[54:14];
        D_Y:     y_q   <= acc_d[54:14];
        D_NX:    nx_q  <= acc_d[NUM_W-1:0];
        D_NY:    ny_q  <= acc_d[NUM_W-1:0];
        D_IDX:   idx_q <= acc_d;
        default: ;
      endcase
    end
  end

  // restoring dividers, one quotient bit per cycle for both coordinates
  logic [NUM_W-2:0] magx_q, magy_q;
  logic [40:0]      remx_q, remy_q;
  logic             negx_q, negy_q;
  logic [41:0]      trialx, trialy, diffx, diffy;
  logic [NUM_W-1:0] absx, absy;

  assign absx   = nx_q[NUM_W-1] ? -nx_q : nx_q;
  assign absy   = ny_q[NUM_W-1] ? -ny_q : ny_q;
  assign trialx = {remx_q, magx_q[NUM_W-2]};
  assign trialy = {remy_q, magy_q[NUM_W-2]};
  assign diffx  = trialx - {1'b0, z_q};
  assign diffy  = trialy - {1'b0, z_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      magx_q <= absx[NUM_W-2:0];
      magy_q <= absy[NUM_W-2:0];
      negx_q <= nx_q[NUM_W-1];
      negy_q <= ny_q[NUM_W-1];
      remx_q <= '0;
      remy_q <= '0;
    end else if (cmd_i.div_step) begin
      remx_q <= diffx[41] ? trialx[40:0] : diffx[40:0];
      remy_q <= diffy[41] ? trialy[40:0] : diffy[40:0];
      magx_q <= {magx_q[NUM_W-3:0], ~diffx[41]};
      magy_q <= {magy_q[NUM_W-3:0], ~diffy[41]};
    end
    if (cmd_i.div_fix) begin
      xq_q <= negx_q ? -{1'b0, magx_q} : {1'b0, magx_q};
      yq_q <= negy_q ? -{1'b0, magy_q} : {1'b0, magy_q};
    end
  end

  // depth key, saturated
  logic [15:0] key;
  assign key = (|z_q[40:37]) ? FAR_DEPTH : z_q[36:21];

  // clearing pass counter
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // glyph and depth memories
  logic [7:0]    glyph_mem [CELLS];
  logic [15:0]   depth_mem [CELLS];
  logic [AW-1:0] mem_addr;
  logic          mem_we, mem_re;
  logic [7:0]    wr_glyph, rd_glyph_q;
  logic [15:0]   wr_depth, rd_depth_q;

  always_comb begin
    if (cmd_i.clr) begin
      mem_addr = clr_cnt_q;
    end else if (cmd_i.rd_plot || cmd_i.wr_plot) begin
      mem_addr = idx_q[AW-1:0];
    end else begin
      mem_addr = AW'(cell_q);
    end
    mem_we   = cmd_i.clr | cmd_i.wr_blank | cmd_i.wr_plot;
    mem_re   = cmd_i.rd_cell | cmd_i.rd_plot;
    wr_glyph = cmd_i.wr_plot ? glyph_q : BLANK_GLYPH;
    wr_depth = cmd_i.wr_plot ? key : FAR_DEPTH;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) glyph_mem[mem_addr] <= wr_glyph;
    if (mem_re) rd_glyph_q <= glyph_mem[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) depth_mem[mem_addr] <= wr_depth;
    if (mem_re) rd_depth_q <= depth_mem[mem_addr];
  end

  // output register
  logic      out_valid_q;
  out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.out_load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q.cell_glyph      <= sts_o.cell_ok ? rd_glyph_q : BLANK_GLYPH;
      out_item_q.cell_index_echo <= cell_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // status
  assign sts_o.z_pos    = ~z_q[40] & (|z_q);
  assign sts_o.idx_ok   = ~idx_q[63] & (idx_q[62:0] < 63'(CELLS));
  assign sts_o.cell_ok  = 32'(cell_q) < 32'(CELLS);
  assign sts_o.nearer   = key < rd_depth_q;
  assign sts_o.clr_last = clr_cnt_q == AW'(CELLS - 1);
  assign sts_o.out_free = ~out_valid_q | ~out_stall_i;

endmodule

`default_nettype wire

[test/point_rotate_project_zbuffer_top_tb.sv]
// ----------------------------------------------------------------------------
// point_rotate_project_zbuffer_top_tb
// Self-checking bench for the rotate, project and z-buffer block. Plot beats
// update a cycle-free model of the glyph and depth grids. Read beats queue the
// predicted glyph, and every output beat is compared against that queue.
// Both channels idle and stall at random, and the rotation, distance and
// scale registers are swept through several settings, the extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module point_rotate_project_zbuffer_top_tb import prpz_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_W     = 160;
  localparam int SCR_H     = 44;
  localparam int HALF_CUBE = 20;
  localparam int CELLS     = SCR_W * SCR_H;
  localparam int Q14       = 16384;
  localparam int BUSY_WAIT = 120;
  localparam int IDLE_LIMIT = 30000;
  localparam logic CMD_PLOT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  point_rotate_project_zbuffer_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // clock
  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // grid model and register copies
  logic [7:0]  glyph_grid [CELLS];
  logic [15:0] depth_grid [CELLS];
  longint      rot_cos_a, rot_sin_a, rot_cos_b, rot_sin_b, rot_cos_c, rot_sin_c;
  longint      cam_dist, proj_k;
  out_item_t   glyph_q [$];
  int          drawn_cells [$];
  int          err_count = 0;
  bit          stall_quiet = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic longint floor_q14(input longint v);
    longint q;
    q = v / Q14;
    if (v % Q14 < 0) q -= 1;
    return q;
  endfunction

  // projected cell of a point, -1 when behind camera or off screen
  function automatic int project_cell(input in_item_t it, output logic [15:0] key);
    longint i, j, k, x42, y42, z, x, y, xp, yp, idx, kz;
    i = longint'($signed(it.point_i)) / 4;
    j = longint'($signed(it.point_j)) / 4;
    k = longint'($signed(it.point_k)) / 4;
    key = FAR_DEPTH;
    x42 = j * rot_sin_a * rot_sin_b * rot_cos_c - k * rot_cos_a * rot_sin_b * rot_cos_c
        + j * rot_cos_a * rot_sin_c * Q14 + k * rot_sin_a * rot_sin_c * Q14
        + i * rot_cos_b * rot_cos_c * Q14;
    y42 = j * rot_cos_a * rot_cos_c * Q14 + k * rot_sin_a * rot_cos_c * Q14
        - j * rot_sin_a * rot_sin_b * rot_sin_c + k * rot_cos_a * rot_sin_b * rot_sin_c
        - i * rot_cos_b * rot_sin_c * Q14;
    z = k * rot_cos_a * rot_cos_b - j * rot_sin_a * rot_cos_b + i * rot_sin_b * Q14
      + cam_dist * Q14 * Q14;
    if (z <= 0) return -1;
    x = floor_q14(x42);
    y = floor_q14(y42);
    xp = (longint'(SCR_W / 2 - 2 * HALF_CUBE) * z + 2 * proj_k * x) / z;
    yp = (longint'(SCR_H / 2) * z + proj_k * y) / z;
    idx = xp + yp * SCR_W;
    if (idx < 0 || idx >= CELLS) return -1;
    kz = z / (longint'(1) << 21);
    if (kz > 65535) kz = 65535;
    key = kz[15:0];
    return int'(idx);
  endfunction

  // apply one accepted beat to the model
  task automatic model_beat(input in_item_t it);
    logic [15:0] key;
    int          c;
    out_item_t   r;
    if (it.cmd == CMD_PLOT) begin
      c = project_cell(it, key);
      if (c >= 0 && key < depth_grid[c]) begin
        depth_grid[c] = key;
        glyph_grid[c] = it.glyph;
        drawn_cells.push_back(c);
        if (drawn_cells.size() > 64) void'(drawn_cells.pop_front());
      end
    end else begin
      r.cell_index_echo = it.cell_index;
      if (it.cell_index < CELLS) begin
        r.cell_glyph = glyph_grid[it.cell_index];
        glyph_grid[it.cell_index] = BLANK_GLYPH;
        depth_grid[it.cell_index] = FAR_DEPTH;
      end else begin
        r.cell_glyph = BLANK_GLYPH;
      end
      glyph_q.push_back(r);
    end
  endtask

  // gap length: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one input beat and wait for it to be taken
  task automatic send_beat(input in_item_t it);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    model_beat(it);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic lower_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // wait until every read beat has come back
  task automatic wait_drained();
    while (glyph_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_COS_A:      rot_cos_a = longint'($signed(data));
      REG_SIN_A:      rot_sin_a = longint'($signed(data));
      REG_COS_B:      rot_cos_b = longint'($signed(data));
      REG_SIN_B:      rot_sin_b = longint'($signed(data));
      REG_COS_C:      rot_cos_c = longint'($signed(data));
      REG_SIN_C:      rot_sin_c = longint'($signed(data));
      REG_CAM_DIST:   cam_dist  = longint'(data[7:0]);
      REG_PROJ_SCALE: proj_k    = longint'(data[7:0]);
      default: ;
    endcase
  endtask

  // block must be idle: results drained and any plot finished
  task automatic set_regs(input logic [15:0] ca, sa, cb, sb, cc, sc, cam, k);
    wait_drained();
    repeat (BUSY_WAIT) @(posedge clk_i);
    cfg_write(REG_COS_A, ca);
    cfg_write(REG_SIN_A, sa);
    cfg_write(REG_COS_B, cb);
    cfg_write(REG_SIN_B, sb);
    cfg_write(REG_COS_C, cc);
    cfg_write(REG_SIN_C, sc);
    cfg_write(REG_CAM_DIST, cam);
    cfg_write(REG_PROJ_SCALE, k);
  endtask

  function automatic in_item_t plot_item(input int pi, pj, pk, input int g);
    in_item_t it;
    it.cmd        = CMD_PLOT;
    it.point_i    = pi[7:0];
    it.point_j    = pj[7:0];
    it.point_k    = pk[7:0];
    it.glyph      = g[7:0];
    it.cell_index = 13'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(input int c);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.cmd        = CMD_READ;
    it.cell_index = c[12:0];
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return plot_item($urandom, $urandom, $urandom, $urandom);
    if (p < 90 && drawn_cells.size() != 0)
      return read_item(drawn_cells[$urandom_range(0, drawn_cells.size() - 1)]);
    return read_item($urandom_range(0, 8191));
  endfunction

  // reads of a freshly cleared grid, in and beyond the screen
  task automatic test_blank_reads();
    send_beat(read_item(0));
    send_beat(read_item(CELLS - 1));
    send_beat(read_item(CELLS));
    send_beat(read_item(8191));
    send_beat(read_item(3520));
    lower_valid();
  endtask

  // coordinate extremes, ties, points behind the camera, read back
  task automatic test_directed_plots();
    logic [15:0] key;
    in_item_t    it;
    int          c;
    it = plot_item(0, 0, 0, 8'h41);
    send_beat(it);
    send_beat(plot_item(0, 0, 0, 8'h42));
    send_beat(plot_item(-128, -128, -128, 8'hff));
    send_beat(plot_item(127, 127, 127, 8'h00));
    send_beat(plot_item(-3, 3, -1, 8'h55));
    send_beat(plot_item(0, 0, -128, 8'haa));
    c = project_cell(it, key);
    send_beat(read_item(c));
    send_beat(read_item(c));
    lower_valid();
    // camera at zero distance puts half the points behind it
    set_regs(16'd16384, 16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd255);
    send_beat(plot_item(0, 0, 0, 8'h11));
    send_beat(plot_item(0, 0, -4, 8'h12));
    send_beat(plot_item(0, 0, 4, 8'h13));
    send_beat(plot_item(8, -8, 4, 8'h14));
    for (int n = 0; n < 4 && drawn_cells.size() != 0; n++)
      send_beat(read_item(drawn_cells[drawn_cells.size() - 1 - n % drawn_cells.size()]));
    lower_valid();
  endtask

  // register sweeps with random traffic in each setting
  task automatic test_register_sweep();
    logic [15:0] pos, neg, zero;
    pos = 16'd16384; neg = -16'sd16384; zero = 16'd0;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_regs(pos, zero, pos, zero, pos, zero, 16'd100, 16'd40);
        1: set_regs(neg, pos, zero, neg, pos, pos, 16'd255, 16'd255);
        2: set_regs(zero, neg, neg, pos, neg, zero, 16'd0, 16'd0);
        3: set_regs(16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h4000, 16'hc000,
                    16'hff80, 16'h0001);
        4: set_regs(16'd11585, 16'd11585, 16'd15137, 16'd6270, 16'd14189, -16'sd8192,
                    16'd60, 16'd30);
        default: set_regs(16'($urandom_range(0, 32768) - 16384),
                          16'($urandom_range(0, 32768) - 16384),
                          16'($urandom_range(0, 32768) - 16384),
                          16'($urandom_range(0, 32768) - 16384),
                          16'($urandom_range(0, 32768) - 16384),
                          16'($urandom_range(0, 32768) - 16384),
                          16'($urandom), 16'($urandom));
      endcase
      stall_quiet = (ph == 5);
      for (int n = 0; n < 100; n++) begin
        send_beat(rand_item());
        if (n == 50 && ph == 2) begin
          lower_valid();
          wait_drained();
        end
      end
      lower_valid();
    end
    stall_quiet = 1'b0;
  endtask

  // output stall pattern: random runs, quiet during one sweep phase
  initial begin
    int len;
    out_stall_i = 1'b0;
    forever begin
      len = pick_gap();
      @(negedge clk_i);
      out_stall_i <= !stall_quiet && len > 0;
      repeat (len > 0 ? len - 1 : 0) @(negedge clk_i);
      len = $urandom_range(1, 6);
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat (len - 1) @(negedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (glyph_q.size() == 0) begin
        report($sformatf("unexpected beat glyph %0d cell %0d",
                         out_item_o.cell_glyph, out_item_o.cell_index_echo));
      end else begin
        want = glyph_q.pop_front();
        if (out_item_o.cell_glyph !== want.cell_glyph)
          report($sformatf("cell %0d glyph %0d, want %0d", want.cell_index_echo,
                           out_item_o.cell_glyph, want.cell_glyph));
        if (out_item_o.cell_index_echo !== want.cell_index_echo)
          report($sformatf("echo %0d, want %0d",
                           out_item_o.cell_index_echo, want.cell_index_echo));
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    static int idle_cycles = 0;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // main sequence
  initial begin
    in_valid_i = 1'b0;
    in_item_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    for (int c = 0; c < CELLS; c++) begin
      glyph_grid[c] = BLANK_GLYPH;
      depth_grid[c] = FAR_DEPTH;
    end
    rot_cos_a = Q14; rot_sin_a = 0;
    rot_cos_b = Q14; rot_sin_b = 0;
    rot_cos_c = Q14; rot_sin_c = 0;
    cam_dist = 100; proj_k = 40;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_blank_reads();
    test_directed_plots();
    test_register_sweep();

    wait_drained();
    repeat (BUSY_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
